// File: rtl/pit_pkg.sv
// Shared types and constants for the process id table.
// No dependencies; used by pit_engine and process_id_table.
package pit_pkg;

  localparam int unsigned IdW    = 15;
  localparam int unsigned SelW   = 16;
  localparam int unsigned ValW   = 16;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;

  localparam logic [IdW-1:0] IdTop   = 15'h7FFF;
  localparam logic [IdW-1:0] IdFirst = 15'd1;

  typedef enum logic [1:0] {
    OP_CREATE     = 2'd0,
    OP_TERMINATE  = 2'd1,
    OP_SEL_FOR_ID = 2'd2,
    OP_ID_AT_SLOT = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e          op;
    logic [SelW-1:0]  sel;
    logic [IdW-1:0]   key;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [SelW-1:0]  sel;
  } entry_t;

  typedef struct packed {
    logic [ValW-1:0]   value;
    logic              success;
    logic              stored;
    logic [CountW-1:0] count;
  } res_t;

endpackage

// File: rtl/pit_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pit_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pit_engine.sv
// Command sequencer of the process id table: scans the entry RAM, one read per cycle,
// and writes back the modified entry. Depends on pit_pkg and pit_ram.
module pit_engine #(
  parameter int unsigned TableDepth = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pit_pkg::cmd_t cmd_i,
  output logic          idle_o,
  output logic          res_valid_o,
  output pit_pkg::res_t res_o,
  input  logic          res_take_i
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned EntW = $bits(pit_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SLOT = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          issue_q, issue_d;
  logic                     pend_q, pend_d;
  logic                     free_found_q, free_found_d;
  logic [pit_pkg::IdW-1:0]  next_id_q, next_id_d;
  logic [pit_pkg::IdW-1:0]  cand_q, cand_d;
  logic [IdxW-1:0]          free_idx_q, free_idx_d;
  logic [IdxW-1:0]          chk_idx_q, chk_idx_d;
  pit_pkg::cmd_t            cmd_q, cmd_d;
  pit_pkg::res_t            res_q, res_d;

  logic                     ram_we, ram_re;
  logic [IdxW-1:0]          ram_waddr, ram_raddr;
  pit_pkg::entry_t          ram_wdata, ent;
  logic [EntW-1:0]          ram_rdata;

  logic                     hit, scan_end, slot_ok, finish;
  logic [pit_pkg::ValW-1:0] fin_value;
  logic [pit_pkg::IdW-1:0]  id_inc;

  pit_ram #(
    .Width (EntW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent      = pit_pkg::entry_t'(ram_rdata);
  assign id_inc   = (next_id_q == pit_pkg::IdTop || next_id_q == '0) ? pit_pkg::IdFirst
                                                                       : next_id_q + 1'b1;
  assign slot_ok  = 32'(cmd_i.slot) < 32'(count_q);
  assign scan_end = !pend_q && (issue_q >= count_q);

  always_comb begin
    hit = 1'b0;
    if (pend_q && ent.valid) begin
      case (cmd_q.op)
        pit_pkg::OP_CREATE:     hit = ent.id == cand_q;
        pit_pkg::OP_TERMINATE:  hit = ent.sel == cmd_q.sel;
        pit_pkg::OP_SEL_FOR_ID: hit = ent.id == cmd_q.key;
        default:                hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    free_found_d = free_found_q;
    next_id_d    = next_id_q;
    cand_d       = cand_q;
    free_idx_d   = free_idx_q;
    chk_idx_d    = chk_idx_q;
    cmd_d        = cmd_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = ent;
    ram_re       = 1'b0;
    ram_raddr    = issue_q[IdxW-1:0];
    finish       = 1'b0;
    fin_value    = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d        = cmd_i;
          issue_d      = '0;
          free_found_d = 1'b0;
          case (cmd_i.op)
            pit_pkg::OP_CREATE: begin
              cand_d    = next_id_q;
              next_id_d = id_inc;
              state_d   = S_SCAN;
            end
            pit_pkg::OP_ID_AT_SLOT: begin
              if (slot_ok) begin
                ram_re    = 1'b1;
                ram_raddr = IdxW'(cmd_i.slot);
                state_d   = S_SLOT;
              end else begin
                finish = 1'b1;
              end
            end
            default: state_d = S_SCAN;
          endcase
        end
      end

      S_SCAN: begin
        if (!hit && issue_q < count_q) begin
          ram_re    = 1'b1;
          pend_d    = 1'b1;
          chk_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + 1'b1;
        end
        if (cmd_q.op == pit_pkg::OP_CREATE) begin
          if (pend_q && !ent.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
          if (hit) begin
            cand_d    = next_id_q;
            next_id_d = id_inc;
            issue_d   = '0;
            pend_d    = 1'b0;
          end else if (scan_end) begin
            ram_wdata = '{valid: 1'b1, id: cand_q, sel: cmd_q.sel};
            if (free_found_q) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_q;
            end else if (count_q < CntW'(TableDepth)) begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IdxW-1:0];
              count_d   = count_q + 1'b1;
            end
            fin_value = pit_pkg::ValW'(cand_q);
            finish    = 1'b1;
          end
        end else if (hit) begin
          if (cmd_q.op == pit_pkg::OP_TERMINATE) begin
            ram_we          = 1'b1;
            ram_wdata       = ent;
            ram_wdata.valid = 1'b0;
            if (CntW'(chk_idx_q) + 1'b1 == count_q) begin
              count_d = count_q - 1'b1;
            end
          end else begin
            fin_value = ent.sel;
          end
          finish = 1'b1;
        end else if (scan_end) begin
          finish = 1'b1;
        end
      end

      S_SLOT: begin
        fin_value = ent.valid ? pit_pkg::ValW'(ent.id) : '0;
        finish    = 1'b1;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      res_d.value   = fin_value;
      res_d.success = (cmd_d.op == pit_pkg::OP_TERMINATE) || (fin_value != '0);
      res_d.stored  = ram_we && (cmd_d.op == pit_pkg::OP_CREATE);
      res_d.count   = pit_pkg::CountW'(count_d);
      state_d       = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      free_found_q <= 1'b0;
      next_id_q    <= pit_pkg::IdFirst;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      issue_q      <= issue_d;
      pend_q       <= pend_d;
      free_found_q <= free_found_d;
      next_id_q    <= next_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    free_idx_q <= free_idx_d;
    chk_idx_q  <= chk_idx_d;
    cmd_q      <= cmd_d;
    res_q      <= res_d;
  end

  assign idle_o      = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

endmodule

// File: rtl/process_id_table.sv
// Top level of the process id table: input handshake, output register, command engine.
// Depends on pit_pkg and pit_engine.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | opcode_i selector_in_i id_key_i slot_index_i
//   out     | output    | out_valid_o/out_stall_i | value_o success_o stored_o entry_count_o
//
// Terminate and selector lookup scan the slots in use, one read of the entry RAM per cycle.
// Create scans once per id candidate and starts the scan again whenever the candidate is
// already in use. Id at slot reads the given slot only when it lies below the count.
// Reset clears the count and sets the next id to 1; the RAM needs no clearing, since only
// slots below the count are read. A stalled result waits in the output register while the
// next transaction is taken.
module process_id_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] selector_in_i,
  input  logic [14:0] id_key_i,
  input  logic [5:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] value_o,
  output logic        success_o,
  output logic        stored_o,
  output logic [6:0]  entry_count_o
);

  logic          eng_idle, eng_res_valid, res_take, start;
  pit_pkg::cmd_t cmd;
  pit_pkg::res_t eng_res, out_q;
  logic          out_valid_q, out_valid_d;

  assign cmd = '{op:   pit_pkg::opcode_e'(opcode_i),
                 sel:  selector_in_i,
                 key:  id_key_i,
                 slot: slot_index_i};

  assign in_stall_o = !eng_idle;
  assign start      = in_valid_i && eng_idle;
  assign res_take   = eng_res_valid && (!out_valid_q || !out_stall_i);

  pit_engine #(
    .TableDepth (TABLE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .idle_o      (eng_idle),
    .res_valid_o (eng_res_valid),
    .res_o       (eng_res),
    .res_take_i  (res_take)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= eng_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_q.value;
  assign success_o     = out_q.success;
  assign stored_o      = out_q.stored;
  assign entry_count_o = out_q.count;

endmodule
